// ===== rtl/pchc_pkg.sv =====
// Shared types and constants of the four-channel pressure hysteresis controller.
// No dependencies; pchc_valve_delay, pchc_channel and the top level import this package.
`default_nettype none

package pchc_pkg;

  localparam int REG_W = 16;
  localparam int IDX_W = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_VALVE_BASE = 3'd0;
  localparam logic [IDX_W-1:0] REG_VALVE_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_HYST_HF    = 3'd2;
  localparam logic [IDX_W-1:0] REG_HYST_HN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_HYST_LN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_HYST_LF    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ZERO_LEVEL = 3'd6;
  localparam logic [IDX_W-1:0] REG_ZERO_HOLD  = 3'd7;

  // Item modes
  localparam logic [1:0] MODE_TICK       = 2'd0;
  localparam logic [1:0] MODE_SET_TARGET = 2'd1;
  localparam logic [1:0] MODE_LOOP_EN    = 2'd2;

  // Phase codes as reported on the result
  localparam logic [1:0] PH_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PH_CODE_INFLATE = 2'd1;
  localparam logic [1:0] PH_CODE_DEFLATE = 2'd2;

  // Divide by 100: quarter the value, then multiply by ceil(2^34 / 25) and keep bits 34 up.
  // Exact for any dividend below 2^31.
  localparam int DIV_SHIFT = 34;
  localparam longint unsigned DIV_RECIP_L = ((64'd1 << DIV_SHIFT) + 64'd24) / 64'd25;
  localparam logic [29:0] DIV_RECIP = DIV_RECIP_L[29:0];

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_INFLATE = 3'b010,
    PH_DEFLATE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [15:0]        valve_base;
    logic [15:0]        valve_gain;
    logic signed [7:0]  hyst_high_far;
    logic signed [7:0]  hyst_high_near;
    logic signed [7:0]  hyst_low_near;
    logic signed [7:0]  hyst_low_far;
    logic signed [7:0]  zero_level;
    logic [15:0]        zero_hold_time;
  } pchc_cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        now;
    logic signed [15:0] pressure_a;
    logic signed [15:0] pressure_b;
    logic signed [15:0] pressure_c;
    logic signed [15:0] pressure_d;
    logic               run_control;
    logic [1:0]         channel;
    logic [15:0]        target_value;
    logic               enable;
  } pchc_item_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pchc_stage_en_t;

  typedef struct packed {
    logic        upd;
    logic [1:0]  mode;
    logic        ctl_tick;
    logic        set_sel;
    logic [31:0] now;
    logic [15:0] target_value;
  } pchc_chan_ctl_t;

  typedef struct packed {
    logic   pump;
    logic   valve;
    logic   done;
    phase_t phase;
  } pchc_chan_stat_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_INFLATE: code = PH_CODE_INFLATE;
      PH_DEFLATE: code = PH_CODE_DEFLATE;
      default:    code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pchc_in_if.sv =====
// Input channel of the pressure hysteresis controller: valid/ready plus the item fields.
// No dependencies.
`default_nettype none

interface pchc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] now;
  logic signed [15:0] pressure_a;
  logic signed [15:0] pressure_b;
  logic signed [15:0] pressure_c;
  logic signed [15:0] pressure_d;
  logic               run_control;
  logic [1:0]         channel;
  logic [15:0]        target_value;
  logic               enable;

  modport source (
    output valid, mode, now, pressure_a, pressure_b, pressure_c, pressure_d,
           run_control, channel, target_value, enable,
    input  ready
  );
  modport sink (
    input  valid, mode, now, pressure_a, pressure_b, pressure_c, pressure_d,
           run_control, channel, target_value, enable,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pchc_out_if.sv =====
// Result channel of the pressure hysteresis controller: valid/ready plus the result fields.
// No dependencies.
`default_nettype none

interface pchc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pump_mask;
  logic [3:0] valve_mask;
  logic [3:0] done_mask;
  logic [1:0] phase_a;
  logic [1:0] phase_b;
  logic [1:0] phase_c;
  logic [1:0] phase_d;
  logic       loop_on;

  modport source (
    output valid, pump_mask, valve_mask, done_mask, phase_a, phase_b, phase_c,
           phase_d, loop_on,
    input  ready
  );
  modport sink (
    input  valid, pump_mask, valve_mask, done_mask, phase_a, phase_b, phase_c,
           phase_d, loop_on,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pchc_valve_delay.sv =====
// Three-stage valve delay datapath: base + gain * pressure / 100, truncated toward zero.
// Depends on pchc_pkg.
`default_nettype none

module pchc_valve_delay
  import pchc_pkg::*;
(
  input  wire logic               clk,
  input  wire pchc_stage_en_t     en,
  input  wire logic signed [15:0] pressure,
  input  wire logic [15:0]        gain,
  input  wire logic [15:0]        base,
  output logic [31:0]             delay
);

  logic [15:0] p_abs;
  logic [31:0] prod;
  logic [58:0] scaled;

  logic        neg1;
  logic [30:0] mag;
  logic        neg2;
  logic [24:0] quot;

  // Work on the magnitude so the divide truncates toward zero
  assign p_abs  = pressure[15] ? (~pressure + 16'd1) : pressure;
  assign prod   = gain * p_abs;
  assign scaled = {30'd0, mag[30:2]} * {29'd0, DIV_RECIP};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1 <= pressure[15];
      mag  <= prod[30:0];
    end
    if (en.s2) begin
      neg2 <= neg1;
      quot <= scaled[58:DIV_SHIFT];
    end
    if (en.s3) begin
      delay <= {16'd0, base} + (neg2 ? -{7'd0, quot} : {7'd0, quot});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pchc_channel.sv =====
// State and next-state logic of one regulation channel: timers, hysteresis phase, clearing.
// Depends on pchc_pkg.
`default_nettype none

module pchc_channel
  import pchc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pchc_chan_ctl_t     ctl,
  input  wire logic signed [15:0] pressure,
  input  wire logic [31:0]        delay,
  input  wire pchc_cfg_t          cfg,
  output pchc_chan_stat_t         stat
);

  phase_t      phase, phase_next;
  logic        done, done_next;
  logic        pump, pump_next;
  logic        valve, valve_next;
  logic        vwait, vwait_next;
  logic        zwait, zwait_next;
  logic [15:0] target, target_next;
  logic [31:0] vdue, vdue_next;
  logic [31:0] zdue, zdue_next;

  logic signed [17:0] delta;
  logic signed [17:0] hf, hn, ln, lf;
  logic signed [15:0] zl;
  logic               vdue_hit, zdue_hit, p_low, clr;

  assign delta = {{2{pressure[15]}}, pressure} - {2'b00, target};
  assign hf    = {{10{cfg.hyst_high_far[7]}},  cfg.hyst_high_far};
  assign hn    = {{10{cfg.hyst_high_near[7]}}, cfg.hyst_high_near};
  assign ln    = {{10{cfg.hyst_low_near[7]}},  cfg.hyst_low_near};
  assign lf    = {{10{cfg.hyst_low_far[7]}},   cfg.hyst_low_far};
  assign zl    = {{8{cfg.zero_level[7]}},      cfg.zero_level};

  assign vdue_hit = $signed(ctl.now) >= $signed(vdue);
  assign zdue_hit = $signed(ctl.now) >= $signed(zdue);
  assign p_low    = pressure <= zl;

  always_comb begin
    phase_next  = phase;
    done_next   = done;
    pump_next   = pump;
    valve_next  = valve;
    vwait_next  = vwait;
    zwait_next  = zwait;
    target_next = target;
    vdue_next   = vdue;
    zdue_next   = zdue;
    clr         = 1'b0;

    case (ctl.mode)
      MODE_TICK: begin
        if (vwait && vdue_hit) begin
          vwait_next = 1'b0;
          valve_next = 1'b1;
        end
        if (zwait && zdue_hit) begin
          zwait_next = 1'b0;
          done_next  = 1'b1;
          if (phase != PH_IDLE) begin
            vwait_next = 1'b0;
            pump_next  = 1'b0;
            valve_next = 1'b0;
            phase_next = PH_IDLE;
          end
        end
        if (ctl.ctl_tick) begin
          case (phase_next)
            PH_INFLATE: begin
              if (delta >= hn) begin
                vwait_next = 1'b0;
                pump_next  = 1'b0;
                valve_next = 1'b0;
                phase_next = PH_IDLE;
                done_next  = 1'b1;
              end
            end
            PH_DEFLATE: begin
              if (delta <= ln) begin
                vwait_next = 1'b0;
                pump_next  = 1'b0;
                valve_next = 1'b0;
                phase_next = PH_IDLE;
                done_next  = 1'b1;
              end
              // Arm the zero hold even when the channel just went idle
              if (!zwait_next && p_low) begin
                zwait_next = 1'b1;
                zdue_next  = ctl.now + {16'd0, cfg.zero_hold_time};
              end
            end
            default: begin
              if (delta > hf && !done_next) begin
                vwait_next = 1'b0;
                pump_next  = 1'b0;
                valve_next = 1'b1;
                phase_next = PH_DEFLATE;
              end
              // Inflate wins over a deflate taken just above; the valve stays open
              if (delta < lf) begin
                pump_next  = 1'b1;
                vwait_next = 1'b1;
                vdue_next  = ctl.now + delay;
                phase_next = PH_INFLATE;
              end
            end
          endcase
        end
      end
      MODE_SET_TARGET: begin
        if (ctl.set_sel && ctl.target_value != target) begin
          target_next = ctl.target_value;
          clr         = 1'b1;
        end
      end
      MODE_LOOP_EN: begin
        clr = 1'b1;
      end
      default: ;
    endcase

    if (clr) begin
      done_next  = 1'b0;
      vwait_next = 1'b0;
      zwait_next = 1'b0;
      if (phase != PH_IDLE) begin
        pump_next  = 1'b0;
        valve_next = 1'b0;
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      done   <= 1'b0;
      pump   <= 1'b0;
      valve  <= 1'b0;
      vwait  <= 1'b0;
      zwait  <= 1'b0;
      target <= 16'd0;
    end else if (ctl.upd) begin
      phase  <= phase_next;
      done   <= done_next;
      pump   <= pump_next;
      valve  <= valve_next;
      vwait  <= vwait_next;
      zwait  <= zwait_next;
      target <= target_next;
    end
  end

  // Due times are only read while their wait flag is set
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      vdue <= vdue_next;
      zdue <= zdue_next;
    end
  end

  assign stat.pump  = pump;
  assign stat.valve = valve;
  assign stat.done  = done;
  assign stat.phase = phase;

endmodule

`default_nettype wire

// ===== rtl/four_channel_pressure_hysteresis_ctrl_top.sv =====
// Top level of the four-channel pump and valve pressure regulator.
// Depends on pchc_pkg, pchc_in_if, pchc_out_if, pchc_valve_delay and pchc_channel.
//
//   Port     | Kind          | Direction | Moves
//   ---------+---------------+-----------+-----------------------------------------
//   item     | valid/ready   | in        | tick, set-target or loop-enable command
//   result   | valid/ready   | out       | pump/valve/done masks, phases, loop_on
//   cfg_*    | write strobe  | in        | eight hysteresis and timing registers
//
// One transaction per cycle sustained while the result is taken. Each item
// passes the valve-delay datapath (gain multiply, divide-by-100 reciprocal
// multiply, base add), one register stage each, and then the registered
// channel state update, which puts its result out.
// rst is synchronous, active high: channels idle, targets zero, loop on,
// registers at their documented defaults.
// A held result stalls only the state update; the three front stages keep
// filling, and item.ready drops once all of them hold a transaction.
`default_nettype none

module four_channel_pressure_hysteresis_ctrl_top
  import pchc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data,
  pchc_in_if.sink                item,
  pchc_out_if.source             result
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  pchc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valve_base     <= 16'd100;
      cfg.valve_gain     <= 16'd100;
      cfg.hyst_high_far  <= 8'sd10;
      cfg.hyst_high_near <= 8'sd5;
      cfg.hyst_low_near  <= -8'sd5;
      cfg.hyst_low_far   <= -8'sd10;
      cfg.zero_level     <= 8'sd10;
      cfg.zero_hold_time <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALVE_BASE: cfg.valve_base     <= cfg_data;
        REG_VALVE_GAIN: cfg.valve_gain     <= cfg_data;
        REG_HYST_HF:    cfg.hyst_high_far  <= cfg_data[7:0];
        REG_HYST_HN:    cfg.hyst_high_near <= cfg_data[7:0];
        REG_HYST_LN:    cfg.hyst_low_near  <= cfg_data[7:0];
        REG_HYST_LF:    cfg.hyst_low_far   <= cfg_data[7:0];
        REG_ZERO_LEVEL: cfg.zero_level     <= cfg_data[7:0];
        REG_ZERO_HOLD:  cfg.zero_hold_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage takes a new transaction when empty or when
  // the stage after it moves.
  // ---------------------------------------------------------------------------
  logic           s1_v, s2_v, s3_v, out_valid;
  logic           rdy1, rdy2, rdy3, rdy_out;
  pchc_stage_en_t en;
  logic           upd;
  pchc_item_t     in_item, s1_item, s2_item, s3_item;

  assign rdy_out = !out_valid || result.ready;
  assign rdy3    = !s3_v || rdy_out;
  assign rdy2    = !s2_v || rdy3;
  assign rdy1    = !s1_v || rdy2;

  assign item.ready = rdy1;
  assign en.s1      = item.valid && rdy1;
  assign en.s2      = s1_v && rdy2;
  assign en.s3      = s2_v && rdy3;
  assign upd        = s3_v && rdy_out;

  always_comb begin
    in_item.mode         = item.mode;
    in_item.now          = item.now;
    in_item.pressure_a   = item.pressure_a;
    in_item.pressure_b   = item.pressure_b;
    in_item.pressure_c   = item.pressure_c;
    in_item.pressure_d   = item.pressure_d;
    in_item.run_control  = item.run_control;
    in_item.channel      = item.channel;
    in_item.target_value = item.target_value;
    in_item.enable       = item.enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    s1_v      <= item.valid;
      if (rdy2)    s2_v      <= s1_v;
      if (rdy3)    s3_v      <= s2_v;
      if (rdy_out) out_valid <= s3_v;
    end
  end

  // Hold the command alongside the delay datapath
  always_ff @(posedge clk) begin
    if (en.s1) s1_item <= in_item;
    if (en.s2) s2_item <= s1_item;
    if (en.s3) s3_item <= s2_item;
  end

  // ---------------------------------------------------------------------------
  // Loop enable
  // ---------------------------------------------------------------------------
  logic loop_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_active <= 1'b1;
    end else if (upd && s3_item.mode == MODE_LOOP_EN) begin
      loop_active <= s3_item.enable;
    end
  end

  // ---------------------------------------------------------------------------
  // Channels. Channels past the fourth sample pressure zero and are not shown.
  // ---------------------------------------------------------------------------
  pchc_chan_stat_t stat [CHANNELS];
  logic [3:0]      pm, vm, dm;
  logic [3:0][1:0] ph_code;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic signed [15:0] p_in, p_upd;
    logic [31:0]        delay;
    pchc_chan_ctl_t     ctl;

    if (i == 0) begin : g_pa
      assign p_in  = item.pressure_a;
      assign p_upd = s3_item.pressure_a;
    end else if (i == 1) begin : g_pb
      assign p_in  = item.pressure_b;
      assign p_upd = s3_item.pressure_b;
    end else if (i == 2) begin : g_pc
      assign p_in  = item.pressure_c;
      assign p_upd = s3_item.pressure_c;
    end else if (i == 3) begin : g_pd
      assign p_in  = item.pressure_d;
      assign p_upd = s3_item.pressure_d;
    end else begin : g_pz
      assign p_in  = 16'sd0;
      assign p_upd = 16'sd0;
    end

    assign ctl.upd          = upd;
    assign ctl.mode         = s3_item.mode;
    assign ctl.ctl_tick     = loop_active && s3_item.run_control;
    assign ctl.set_sel      = (32'(s3_item.channel) == i);
    assign ctl.now          = s3_item.now;
    assign ctl.target_value = s3_item.target_value;

    pchc_valve_delay u_delay (
      .clk      (clk),
      .en       (en),
      .pressure (p_in),
      .gain     (cfg.valve_gain),
      .base     (cfg.valve_base),
      .delay    (delay)
    );

    pchc_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .pressure (p_upd),
      .delay    (delay),
      .cfg      (cfg),
      .stat     (stat[i])
    );
  end

  // Result fields come straight from the channel state; it only moves when
  // the previous result has been taken.
  for (genvar i = 0; i < 4; i++) begin : g_out
    if (i < CHANNELS) begin : g_on
      assign pm[i]      = stat[i].pump;
      assign vm[i]      = stat[i].valve;
      assign dm[i]      = stat[i].done;
      assign ph_code[i] = phase_code(stat[i].phase);
    end else begin : g_off
      assign pm[i]      = 1'b0;
      assign vm[i]      = 1'b0;
      assign dm[i]      = 1'b0;
      assign ph_code[i] = PH_CODE_IDLE;
    end
  end

  assign result.valid      = out_valid;
  assign result.pump_mask  = pm;
  assign result.valve_mask = vm;
  assign result.done_mask  = dm;
  assign result.phase_a    = ph_code[0];
  assign result.phase_b    = ph_code[1];
  assign result.phase_c    = ph_code[2];
  assign result.phase_d    = ph_code[3];
  assign result.loop_on    = loop_active;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input backpressure only comes from a held result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready))
    else $error("item.ready low without a stalled result");

  // Channel A's pump runs exactly while that channel inflates
  a_pump_inflate: assert property (@(posedge clk) disable iff (rst)
    result.pump_mask[0] == (result.phase_a == PH_CODE_INFLATE))
    else $error("pump state disagrees with inflate phase");

  // Channel A always has its valve open while deflating
  a_deflate_valve: assert property (@(posedge clk) disable iff (rst)
    (result.phase_a == PH_CODE_DEFLATE) |-> result.valve_mask[0])
    else $error("deflate phase with valve closed");

endmodule

`default_nettype wire
